>>> design/fetq_pkg.sv
// shared constants, codes, types and helpers of the filtered event trace queue
`timescale 1ns / 1ps
`default_nettype none
package fetq_pkg;

  // ring geometry
  localparam int CAPACITY      = 64;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int OCC_W         = ADDR_W + 1;
  localparam int PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
  localparam int KIND_COUNT    = 4;
  localparam int KIND_W        = 2;
  localparam int KIND_IN_W     = 4;
  localparam int TAG_W         = 64;
  localparam int LEN_W         = 4;
  localparam int COUNT_W       = 32;
  localparam int SEQ_W         = 53;
  localparam int STATUS_W      = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 53;

  localparam logic [SEQ_W-1:0] MAX_SEQUENCE = 53'h1F_FFFF_FFFF_FFFF;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KIND_MASK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COALESCE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG_GEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_GEN = 3'd5;

  // request codes
  localparam logic REQ_PUBLISH = 1'b0;
  localparam logic REQ_DRAIN   = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PUBLISHED = 4'd0,
    ST_COALESCED = 4'd1,
    ST_DISABLED  = 4'd2,
    ST_FILTERED  = 4'd3,
    ST_BAD_KIND  = 4'd4,
    ST_TOO_LARGE = 4'd5,
    ST_FULL      = 4'd6,
    ST_SEQ_EXH   = 4'd7,
    ST_DRAINED   = 4'd8,
    ST_EMPTY     = 4'd9
  } status_t;

  // configuration register file contents
  typedef struct packed {
    logic                  enabled;
    logic [KIND_COUNT-1:0] kind_mask;
    logic [LEN_W-1:0]      max_payload_len;
    logic                  coalesce_on_overflow;
    logic [SEQ_W-1:0]      config_generation;
    logic [SEQ_W-1:0]      context_generation;
  } cfg_t;

  // one ring entry
  typedef struct packed {
    logic [TAG_W-1:0]     source;
    logic [TAG_W-1:0]     subject;
    logic [TAG_W-1:0]     correlation;
    logic [PAYLOAD_W-1:0] payload;
    logic [KIND_W-1:0]    kind;
    logic [LEN_W-1:0]     len;
    logic [COUNT_W-1:0]   coalesced;
    logic [SEQ_W-1:0]     generation;
  } entry_t;

  // ring memory access request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // keep the first len bytes of a payload word
  function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PAYLOAD_W-1:0] m;
    m = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      m[8*i +: 8] = (32'(len) > i) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> design/fetq_ifs.sv
// channel interfaces of the filtered event trace queue
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface fetq_req_if;
  import fetq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [KIND_IN_W-1:0]  kind;
  logic [TAG_W-1:0]      source_tag;
  logic [TAG_W-1:0]      subject;
  logic [TAG_W-1:0]      correlation;
  logic [LEN_W-1:0]      payload_len;
  logic [PAYLOAD_W-1:0]  payload_word;
  logic                  coalescible;
  modport source (output valid, req_type, kind, source_tag, subject, correlation,
                  payload_len, payload_word, coalescible, input ready);
  modport sink (input valid, req_type, kind, source_tag, subject, correlation,
                payload_len, payload_word, coalescible, output ready);
endinterface

// result channel
interface fetq_res_if;
  import fetq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SEQ_W-1:0]      sequence_res;
  logic [KIND_W-1:0]     kind_out;
  logic [TAG_W-1:0]      source_out;
  logic [TAG_W-1:0]      subject_out;
  logic [TAG_W-1:0]      correlation_out;
  logic [LEN_W-1:0]      payload_len_out;
  logic [PAYLOAD_W-1:0]  payload_word_out;
  logic [COUNT_W-1:0]    coalesced_before;
  logic [SEQ_W-1:0]      event_config_generation;
  logic [SEQ_W-1:0]      event_context_generation;
  logic                  more_available;
  modport source (output valid, status, sequence_res, kind_out, source_out,
                  subject_out, correlation_out, payload_len_out, payload_word_out,
                  coalesced_before, event_config_generation,
                  event_context_generation, more_available, input ready);
  modport sink (input valid, status, sequence_res, kind_out, source_out,
                subject_out, correlation_out, payload_len_out, payload_word_out,
                coalesced_before, event_config_generation,
                event_context_generation, more_available, output ready);
endinterface

// configuration write channel
interface fetq_cfg_if;
  import fetq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/fetq_cfg_regs.sv
// configuration register file of the filtered event trace queue
`timescale 1ns / 1ps
`default_nettype none
module fetq_cfg_regs
  import fetq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fetq_cfg_if.sink  cfg,
  output cfg_t      regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enabled              <= 1'b0;
      regs.kind_mask            <= '1;
      regs.max_payload_len      <= LEN_W'(PAYLOAD_BYTES);
      regs.coalesce_on_overflow <= 1'b0;
      regs.config_generation    <= SEQ_W'(1);
      regs.context_generation   <= SEQ_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLED:     regs.enabled              <= cfg.data[0];
        REG_KIND_MASK:   regs.kind_mask            <= cfg.data[KIND_COUNT-1:0];
        REG_MAX_LEN:     regs.max_payload_len      <= cfg.data[LEN_W-1:0];
        REG_COALESCE:    regs.coalesce_on_overflow <= cfg.data[0];
        REG_CONFIG_GEN:  regs.config_generation    <= cfg.data[SEQ_W-1:0];
        REG_CONTEXT_GEN: regs.context_generation   <= cfg.data[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/fetq_ring_mem.sv
// ring storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fetq_ring_mem
  import fetq_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t mreq,
  output entry_t        rdata
);

  entry_t ring [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      ring[mreq.waddr] <= mreq.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata <= ring[mreq.raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/fetq_ctrl.sv
// request sequencer: checks, positions, coalesced counts and result register
`timescale 1ns / 1ps
`default_nettype none
module fetq_ctrl
  import fetq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   regs,
  fetq_req_if.sink    req,
  fetq_res_if.source  res,
  output mem_req_t    mreq,
  input  wire entry_t rdata
);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t             state;
  logic [SEQ_W-1:0]   wr_pos;
  logic [SEQ_W-1:0]   rd_pos;
  logic [COUNT_W-1:0] pend [KIND_COUNT];

  logic               accept;
  logic [KIND_W-1:0]  kind_idx;
  logic [OCC_W-1:0]   occ;
  logic               ring_full;
  logic               ring_empty;
  logic [LEN_W-1:0]   limit;
  status_t            pub_status;
  logic [COUNT_W-1:0] pend_cur;
  logic               res_valid_next;

  // handshake: one request in flight, result slot free or draining
  assign req.ready = (state == S_IDLE) && (!res.valid || res.ready);
  assign accept    = req.valid && req.ready;

  // occupancy from the positions, never above capacity
  assign occ        = OCC_W'(wr_pos - rd_pos);
  assign ring_full  = (occ >= OCC_W'(CAPACITY));
  assign ring_empty = (rd_pos == wr_pos);
  assign kind_idx   = req.kind[KIND_W-1:0];
  assign pend_cur   = pend[kind_idx];
  assign limit      = (regs.max_payload_len > LEN_W'(PAYLOAD_BYTES))
                      ? LEN_W'(PAYLOAD_BYTES) : regs.max_payload_len;

  // result slot: filled by a finished request, held until taken
  assign res_valid_next = (state == S_DRAIN)
                          || (accept && !(req.req_type == REQ_DRAIN && !ring_empty))
                          || (res.valid && !res.ready);

  // publish checks in priority order
  always_comb begin
    if (req.kind >= KIND_IN_W'(KIND_COUNT)) begin
      pub_status = ST_BAD_KIND;
    end else if (!regs.enabled) begin
      pub_status = ST_DISABLED;
    end else if (!regs.kind_mask[kind_idx]) begin
      pub_status = ST_FILTERED;
    end else if (req.payload_len > limit) begin
      pub_status = ST_TOO_LARGE;
    end else if (wr_pos >= MAX_SEQUENCE) begin
      pub_status = ST_SEQ_EXH;
    end else if (ring_full) begin
      pub_status = (regs.coalesce_on_overflow && req.coalescible)
                   ? ST_COALESCED : ST_FULL;
    end else begin
      pub_status = ST_PUBLISHED;
    end
  end

  // ring memory requests
  always_comb begin
    mreq.we                = accept && (req.req_type == REQ_PUBLISH)
                             && (pub_status == ST_PUBLISHED);
    mreq.waddr             = wr_pos[ADDR_W-1:0];
    mreq.wdata.source      = req.source_tag;
    mreq.wdata.subject     = req.subject;
    mreq.wdata.correlation = req.correlation;
    mreq.wdata.payload     = req.payload_word & byte_mask(req.payload_len);
    mreq.wdata.kind        = kind_idx;
    mreq.wdata.len         = req.payload_len;
    mreq.wdata.coalesced   = pend_cur;
    mreq.wdata.generation  = regs.config_generation;
    mreq.re                = accept && (req.req_type == REQ_DRAIN) && !ring_empty;
    mreq.raddr             = rd_pos[ADDR_W-1:0];
  end

  // state, positions, pending counts and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_pos    <= '0;
      rd_pos    <= '0;
      res.valid <= 1'b0;
      for (int k = 0; k < KIND_COUNT; k++) begin
        pend[k] <= '0;
      end
    end else begin
      res.valid <= res_valid_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res.kind_out                 <= '0;
            res.source_out               <= '0;
            res.subject_out              <= '0;
            res.correlation_out          <= '0;
            res.payload_len_out          <= '0;
            res.payload_word_out         <= '0;
            res.coalesced_before         <= '0;
            res.event_context_generation <= '0;
            res.more_available           <= 1'b0;
            if (req.req_type == REQ_DRAIN) begin
              // status is replaced when the read data returns
              res.status                  <= ST_EMPTY;
              res.sequence_res            <= '0;
              res.event_config_generation <= '0;
              if (!ring_empty) begin
                rd_pos <= rd_pos + SEQ_W'(1);
                state  <= S_DRAIN;
              end
            end else begin
              res.status                  <= pub_status;
              res.sequence_res            <= (pub_status == ST_PUBLISHED)
                                             ? wr_pos + SEQ_W'(1) : '0;
              res.event_config_generation <= (pub_status != ST_BAD_KIND)
                                             ? regs.config_generation : '0;
              if (pub_status == ST_PUBLISHED) begin
                wr_pos         <= wr_pos + SEQ_W'(1);
                pend[kind_idx] <= '0;
              end else if (pub_status == ST_COALESCED && pend_cur != '1) begin
                pend[kind_idx] <= pend_cur + COUNT_W'(1);
              end
            end
          end
        end
        S_DRAIN: begin
          // read data is back; rd_pos already points past the drained entry
          res.status                   <= ST_DRAINED;
          res.sequence_res             <= rd_pos;
          res.kind_out                 <= rdata.kind;
          res.source_out               <= rdata.source;
          res.subject_out              <= rdata.subject;
          res.correlation_out          <= rdata.correlation;
          res.payload_len_out          <= rdata.len;
          res.payload_word_out         <= rdata.payload;
          res.coalesced_before         <= rdata.coalesced;
          res.event_config_generation  <= rdata.generation;
          res.event_context_generation <= regs.context_generation;
          res.more_available           <= !ring_empty;
          state                        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/filtered_event_trace_queue.sv
// Filtered trace event queue: a 64-entry ring of trace events with filtering and coalescing.
// Publish: result registered in the cycle after acceptance, one publish per cycle while results are taken.
// Drain: the ring read is registered, then the S_DRAIN state loads the result; no request is taken meanwhile.
// Reset (synchronous, active high) clears positions, coalesced counts and result valid, and restores default settings.
// Ring contents are not cleared; no entry is read before it is written.
`timescale 1ns / 1ps
`default_nettype none
module filtered_event_trace_queue
  import fetq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  fetq_cfg_if.sink   cfg,
  fetq_req_if.sink   req,
  fetq_res_if.source res
);

  cfg_t     regs;
  mem_req_t mreq;
  entry_t   rdata;

  // configuration registers
  fetq_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // request sequencer
  fetq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .req   (req),
    .res   (res),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // event ring
  fetq_ring_mem u_ring (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

`ifndef ASSERT_OFF
  // a publish write and a drain read never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mreq.we && mreq.re))
    else $error("ring write and read in the same cycle");

  // a drain read interlocks the request side for the read cycle
  a_drain_interlock: assert property (@(posedge clk) disable iff (rst)
    mreq.re |=> !req.ready)
    else $error("request taken while ring read outstanding");

  // a drain read yields a drained result once the S_DRAIN state has loaded it
  a_drain_result: assert property (@(posedge clk) disable iff (rst)
    mreq.re |-> ##2 (res.valid && res.status == ST_DRAINED))
    else $error("drain read without drained result");

  // writes go only to accepted publish transactions
  a_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (req.valid && req.ready && req.req_type == REQ_PUBLISH))
    else $error("ring write without publish transaction");
`endif

endmodule
`default_nettype wire
